### hw/rtl/asd_pkg.sv
package asd_pkg;

  // one g in accelerometer counts
  localparam logic [15:0] ONE_G_LSB = 16'd4096;

  // default width of the timestamp state
  localparam int unsigned TIME_BITS_DEF = 32;

  // register reset values
  localparam logic [14:0] THRESHOLD_RST = 15'd4915;
  localparam logic [15:0] WINDOW_RST    = 16'd400;
  localparam logic [7:0]  NEEDED_RST    = 8'd4;
  localparam logic [15:0] COOLDOWN_RST  = 16'd3500;

  // field widths
  localparam int unsigned ACCEL_W    = 16;
  localparam int unsigned STAMP_W    = 32;
  localparam int unsigned SQ_W       = 31;
  localparam int unsigned SUM_W      = 32;
  localparam int unsigned CFG_IDX_W  = 8;
  localparam int unsigned CFG_DATA_W = 16;
  localparam int unsigned TALLY_W    = 8;

  // register indexes on the configuration port
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_THRESHOLD = 8'd0,
    CFG_WINDOW    = 8'd1,
    CFG_NEEDED    = 8'd2,
    CFG_COOLDOWN  = 8'd3
  } cfg_idx_e;

  // live configuration
  typedef struct packed {
    logic [14:0] threshold_lsb;
    logic [15:0] window_ms;
    logic [7:0]  needed_samples;
    logic [15:0] cooldown_ms;
  } cfg_t;

  // squared magnitude bounds derived from the threshold
  typedef struct packed {
    logic [SUM_W-1:0] upper_sq;
    logic [24:0]      lower_sq;
    logic             lower_en;
  } bounds_t;

endpackage

### hw/rtl/asd_cfg_regs.sv
module asd_cfg_regs
  import asd_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  output cfg_t                  cfg_o,
  output bounds_t               bounds_o
);

  cfg_t    cfg_q;
  bounds_t bounds_q, bounds_d;

  logic [15:0] upper;
  logic [15:0] thr_ext;
  logic [12:0] lower;
  logic [25:0] lower_prod;

  assign cfg_ready_o = 1'b1;

  // register writes, values cut to their widths, unknown indexes dropped
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.threshold_lsb  <= THRESHOLD_RST;
      cfg_q.window_ms      <= WINDOW_RST;
      cfg_q.needed_samples <= NEEDED_RST;
      cfg_q.cooldown_ms    <= COOLDOWN_RST;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_idx_e'(cfg_index_i))
        CFG_THRESHOLD: cfg_q.threshold_lsb  <= cfg_data_i[14:0];
        CFG_WINDOW:    cfg_q.window_ms      <= cfg_data_i;
        CFG_NEEDED:    cfg_q.needed_samples <= cfg_data_i[7:0];
        CFG_COOLDOWN:  cfg_q.cooldown_ms    <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // squared bounds around one g
  always_comb begin
    thr_ext             = {1'b0, cfg_q.threshold_lsb};
    upper               = ONE_G_LSB + thr_ext;
    lower               = 13'(ONE_G_LSB - thr_ext);
    lower_prod          = 26'(lower) * 26'(lower);
    bounds_d.upper_sq   = SUM_W'(upper) * SUM_W'(upper);
    bounds_d.lower_sq   = lower_prod[24:0];
    bounds_d.lower_en   = thr_ext < ONE_G_LSB;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bounds_q <= '0;
    end else begin
      bounds_q <= bounds_d;
    end
  end

  assign cfg_o    = cfg_q;
  assign bounds_o = bounds_q;

endmodule

### hw/rtl/asd_mag_test.sv
module asd_mag_test
  import asd_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [ACCEL_W-1:0] accel_x_i,
  input  logic [ACCEL_W-1:0] accel_y_i,
  input  logic [ACCEL_W-1:0] accel_z_i,
  input  logic [STAMP_W-1:0] time_ms_i,
  input  bounds_t            bounds_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic               high_o,
  output logic [STAMP_W-1:0] time_ms_o
);

  logic               v1_q, v2_q;
  logic               en1, en2;
  logic [SQ_W-1:0]    sq_x_q, sq_y_q, sq_z_q;
  logic [STAMP_W-1:0] t1_q, t2_q;
  logic               high_q, high_d;
  logic [SUM_W-1:0]   mag_sq;
  logic signed [31:0] px, py, pz;

  // stage moves when empty or when the next one moves
  assign en2        = !v2_q || out_ready_i;
  assign en1        = !v1_q || en2;
  assign in_ready_o = en1;

  // per-axis squares
  always_comb begin
    px = 32'($signed(accel_x_i)) * 32'($signed(accel_x_i));
    py = 32'($signed(accel_y_i)) * 32'($signed(accel_y_i));
    pz = 32'($signed(accel_z_i)) * 32'($signed(accel_z_i));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else if (en1) begin
      v1_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en1 && in_valid_i) begin
      sq_x_q <= px[SQ_W-1:0];
      sq_y_q <= py[SQ_W-1:0];
      sq_z_q <= pz[SQ_W-1:0];
      t1_q   <= time_ms_i;
    end
  end

  // squared magnitude against both bounds
  always_comb begin
    mag_sq = SUM_W'(sq_x_q) + SUM_W'(sq_y_q) + SUM_W'(sq_z_q);
    high_d = (mag_sq > bounds_i.upper_sq) ||
             (bounds_i.lower_en && (mag_sq < SUM_W'(bounds_i.lower_sq)));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
    end else if (en2) begin
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en2 && v1_q) begin
      high_q <= high_d;
      t2_q   <= t1_q;
    end
  end

  assign out_valid_o = v2_q;
  assign high_o      = high_q;
  assign time_ms_o   = t2_q;

endmodule

### hw/rtl/asd_tracker.sv
module asd_tracker
  import asd_pkg::*;
#(
  parameter int unsigned TimeBits = TIME_BITS_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  cfg_t               cfg_i,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic               high_i,
  input  logic [STAMP_W-1:0] time_ms_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic               shake_detected_o,
  output logic               sample_high_o
);

  logic [TimeBits-1:0] win_begin_q, win_begin_d;
  logic [TimeBits-1:0] last_fire_q, last_fire_d;
  logic [TALLY_W-1:0]  tally_q, tally_d, tally_up;
  logic [TimeBits-1:0] now, elapsed, since_fire;
  logic                expired, cool_ok, fire;
  logic                out_v_q, shake_q, high_q;
  logic                en;

  assign en         = !out_v_q || out_ready_i;
  assign in_ready_o = en;

  // window tally and trigger decision
  always_comb begin
    now         = TimeBits'(time_ms_i);
    elapsed     = now - win_begin_q;
    since_fire  = now - last_fire_q;
    expired     = elapsed > TimeBits'(cfg_i.window_ms);
    cool_ok     = since_fire > TimeBits'(cfg_i.cooldown_ms);
    win_begin_d = win_begin_q;
    if (high_i) begin
      if ((tally_q == '0) || expired) begin
        tally_up    = TALLY_W'(1);
        win_begin_d = now;
      end else if (tally_q != '1) begin
        tally_up = tally_q + TALLY_W'(1);
      end else begin
        tally_up = tally_q;
      end
    end else if (expired) begin
      tally_up = '0;
    end else begin
      tally_up = tally_q;
    end
    // zero needed samples acts as one
    fire        = (tally_up != '0) && (tally_up >= cfg_i.needed_samples) && cool_ok;
    tally_d     = fire ? '0 : tally_up;
    last_fire_d = fire ? now : last_fire_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_begin_q <= '0;
      last_fire_q <= '0;
      tally_q     <= '0;
    end else if (in_valid_i && en) begin
      win_begin_q <= win_begin_d;
      last_fire_q <= last_fire_d;
      tally_q     <= tally_d;
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (en) begin
      out_v_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && en) begin
      shake_q <= fire;
      high_q  <= high_i;
    end
  end

  assign out_valid_o      = out_v_q;
  assign shake_detected_o = shake_q;
  assign sample_high_o    = high_q;

endmodule

### hw/rtl/accel_shake_detector_top.sv
// path: a sample passes the square register, the bound test register and the tracker result register
// throughput: one sample per cycle unless the output stalls; the window and cooldown
// state updates with the tracker result register; squares and bounds are registered ahead
// reset: rst_ni async active low; configuration registers return to their defaults,
// window start, tally and last trigger time clear to zero, pipeline empties
module accel_shake_detector_top
  import asd_pkg::*;
#(
  parameter int unsigned TIME_BITS = TIME_BITS_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // x [15:0], y [31:16], z [47:32], time_ms [79:48]
  input  logic [79:0]           s_axis_tdata_i,
  input  logic                  s_axis_tvalid_i,
  output logic                  s_axis_tready_o,
  // shake_detected [0], sample_high [1], zero [7:2]
  output logic [7:0]            m_axis_tdata_o,
  output logic                  m_axis_tvalid_o,
  input  logic                  m_axis_tready_i,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  cfg_t               cfg;
  bounds_t            bounds;
  logic               mid_valid, mid_ready, mid_high;
  logic [STAMP_W-1:0] mid_time;
  logic               shake, high;

  asd_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg),
    .bounds_o    (bounds)
  );

  asd_mag_test u_mag (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid_i),
    .in_ready_o  (s_axis_tready_o),
    .accel_x_i   (s_axis_tdata_i[15:0]),
    .accel_y_i   (s_axis_tdata_i[31:16]),
    .accel_z_i   (s_axis_tdata_i[47:32]),
    .time_ms_i   (s_axis_tdata_i[79:48]),
    .bounds_i    (bounds),
    .out_valid_o (mid_valid),
    .out_ready_i (mid_ready),
    .high_o      (mid_high),
    .time_ms_o   (mid_time)
  );

  asd_tracker #(
    .TimeBits (TIME_BITS)
  ) u_trk (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_i            (cfg),
    .in_valid_i       (mid_valid),
    .in_ready_o       (mid_ready),
    .high_i           (mid_high),
    .time_ms_i        (mid_time),
    .out_valid_o      (m_axis_tvalid_o),
    .out_ready_i      (m_axis_tready_i),
    .shake_detected_o (shake),
    .sample_high_o    (high)
  );

  assign m_axis_tdata_o = {6'b0, high, shake};

endmodule
